/* rtl/core/smpq_pkg.sv */
// Shared types and constants for the sorted min-priority queue.
package smpq_pkg;

   localparam int KEY_WIDTH    = 32;
   localparam int HANDLE_WIDTH = 16;
   localparam int COUNT_WIDTH  = 9;

   // Operation codes carried on the request channel
   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   // One stored entry as held by a cell
   typedef struct packed {
      logic                    valid;
      logic [KEY_WIDTH-1:0]    key;
      logic [HANDLE_WIDTH-1:0] handle;
   } entry_type;

   // Per-cycle chain command, shared by every cell
   typedef struct packed {
      logic insert;
      logic remove;
   } chain_ctrl_type;

endpackage

/* rtl/core/smpq_channels.sv */
// Request and response channel interfaces of the sorted min-priority queue.
interface smpq_req_if;
   logic                              valid;
   logic                              ready;
   logic                              opcode;
   logic [smpq_pkg::KEY_WIDTH-1:0]    item_key;
   logic [smpq_pkg::HANDLE_WIDTH-1:0] item_handle;

   modport source (output valid, output opcode, output item_key, output item_handle,
                   input ready);
   modport sink   (input valid, input opcode, input item_key, input item_handle,
                   output ready);
endinterface

interface smpq_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              accepted;
   logic [smpq_pkg::KEY_WIDTH-1:0]    out_key;
   logic [smpq_pkg::HANDLE_WIDTH-1:0] out_handle;
   logic [smpq_pkg::COUNT_WIDTH-1:0]  count_after;
   logic                              is_empty;
   logic                              is_full;

   modport source (output valid, output accepted, output out_key, output out_handle,
                   output count_after, output is_empty, output is_full, input ready);
   modport sink   (input valid, input accepted, input out_key, input out_handle,
                   input count_after, input is_empty, input is_full, output ready);
endinterface

/* rtl/core/smpq_cell.sv */
// One position of the sorted chain: holds an entry and shifts with its neighbors.
module smpq_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  smpq_pkg::chain_ctrl_type          ctrl,
   input  logic [smpq_pkg::KEY_WIDTH-1:0]    new_key,
   input  logic [smpq_pkg::HANDLE_WIDTH-1:0] new_handle,
   input  smpq_pkg::entry_type               left_entry,
   input  logic                              left_ge,
   input  smpq_pkg::entry_type               right_entry,
   output smpq_pkg::entry_type               entry,
   output logic                              ge
);
   import smpq_pkg::*;

   logic                    valid_ff, valid_in;
   logic [KEY_WIDTH-1:0]    key_ff, key_in;
   logic [HANDLE_WIDTH-1:0] handle_ff, handle_in;

   // Flag this position as at or past the insertion point
   assign ge = !valid_ff || (key_ff >= new_key);

   assign entry = '{valid: valid_ff, key: key_ff, handle: handle_ff};

   // Choose between hold, shift from left, take new entry, or shift from right
   always_comb begin
      valid_in  = valid_ff;
      key_in    = key_ff;
      handle_in = handle_ff;
      if (ctrl.insert && ge) begin
         if (left_ge) begin
            valid_in  = left_entry.valid;
            key_in    = left_entry.key;
            handle_in = left_entry.handle;
         end else begin
            valid_in  = 1'b1;
            key_in    = new_key;
            handle_in = new_handle;
         end
      end else if (ctrl.remove) begin
         valid_in  = right_entry.valid;
         key_in    = right_entry.key;
         handle_in = right_entry.handle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      handle_ff <= handle_in;
   end

endmodule

/* rtl/core/sorted_min_priority_queue.sv */
// Response: registered at the output, presented in the cycle after the request transfers.
// Throughput: one request per cycle while the sink takes responses; every cell of the
// shift chain compares and moves in the same cycle; a stalled response blocks requests.
// Reset: synchronous, active high; clears the entry count, every cell valid bit
// and the response valid; stored keys and handles are left as they are.
module sorted_min_priority_queue #(
   parameter int QUEUE_DEPTH = 256
) (
   input logic        clock,
   input logic        reset,
   smpq_req_if.sink   req_chan,
   smpq_rsp_if.source rsp_chan
);
   import smpq_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             full, empty, take, do_insert, do_remove;
   chain_ctrl_type   ctrl;

   entry_type        cell_entry [QUEUE_DEPTH];
   logic             cell_ge    [QUEUE_DEPTH];

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    accepted_ff, accepted_in;
   logic [KEY_WIDTH-1:0]    out_key_ff, out_key_in;
   logic [HANDLE_WIDTH-1:0] out_handle_ff, out_handle_in;
   logic [COUNT_WIDTH-1:0]  count_after_ff, count_after_in;
   logic                    is_empty_ff, is_empty_in;
   logic                    is_full_ff, is_full_in;

   // Accept a request whenever the response register is free or draining
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign take           = req_chan.valid && req_chan.ready;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign do_insert = take && (req_chan.opcode == OP_ENQUEUE) && !full;
   assign do_remove = take && (req_chan.opcode == OP_DEQUEUE) && !empty;
   assign ctrl      = '{insert: do_insert, remove: do_remove};

   // Build the chain of cells
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      entry_type left_entry, right_entry;
      logic      left_ge;

      if (i == 0) begin : g_head
         assign left_entry = '0;
         assign left_ge    = 1'b0;
      end else begin : g_body
         assign left_entry = cell_entry[i-1];
         assign left_ge    = cell_ge[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_entry = '0;
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
      end

      smpq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .new_key     (req_chan.item_key),
         .new_handle  (req_chan.item_handle),
         .left_entry  (left_entry),
         .left_ge     (left_ge),
         .right_entry (right_entry),
         .entry       (cell_entry[i]),
         .ge          (cell_ge[i])
      );
   end

   // Advance the entry count
   always_comb begin
      count_in = count_ff;
      if (do_insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_remove) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Form the response; hold it while the sink stalls
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      accepted_in    = accepted_ff;
      out_key_in     = out_key_ff;
      out_handle_in  = out_handle_ff;
      count_after_in = count_after_ff;
      is_empty_in    = is_empty_ff;
      is_full_in     = is_full_ff;
      if (take) begin
         rsp_valid_in   = 1'b1;
         accepted_in    = do_insert || do_remove;
         out_key_in     = do_remove ? cell_entry[0].key : '0;
         out_handle_in  = do_remove ? cell_entry[0].handle : '0;
         count_after_in = COUNT_WIDTH'(count_in);
         is_empty_in    = (count_in == '0);
         is_full_in     = (count_in == CNT_W'(QUEUE_DEPTH));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      accepted_ff    <= accepted_in;
      out_key_ff     <= out_key_in;
      out_handle_ff  <= out_handle_in;
      count_after_ff <= count_after_in;
      is_empty_ff    <= is_empty_in;
      is_full_ff     <= is_full_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.accepted    = accepted_ff;
   assign rsp_chan.out_key     = out_key_ff;
   assign rsp_chan.out_handle  = out_handle_ff;
   assign rsp_chan.count_after = count_after_ff;
   assign rsp_chan.is_empty    = is_empty_ff;
   assign rsp_chan.is_full     = is_full_ff;

endmodule

/* tb/tb_sorted_min_priority_queue.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the sorted min-priority queue: directed and random traffic.
module tb_sorted_min_priority_queue;
   import smpq_pkg::*;

   localparam int QUEUE_DEPTH  = 256;
   localparam int RANDOM_OPS   = 1440;
   localparam int PHASE_LEN    = 180;
   localparam int DRAIN_CYCLES = 10;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int MAX_PRINTS   = 40;

   // Idle patterns, one per stretch of the random traffic
   localparam logic [1:0] PH_STEADY    = 2'd0;
   localparam logic [1:0] PH_SRC_IDLE  = 2'd1;
   localparam logic [1:0] PH_SINK_STALL = 2'd2;
   localparam logic [1:0] PH_BOTH      = 2'd3;

   typedef struct packed {
      logic                    opcode;
      logic [KEY_WIDTH-1:0]    key;
      logic [HANDLE_WIDTH-1:0] handle;
      logic [1:0]              phase;
   } queue_op_type;

   typedef struct packed {
      logic                    accepted;
      logic [KEY_WIDTH-1:0]    out_key;
      logic [HANDLE_WIDTH-1:0] out_handle;
      logic [COUNT_WIDTH-1:0]  count_after;
      logic                    is_empty;
      logic                    is_full;
   } queue_result_type;

   logic clock;
   logic reset;

   smpq_req_if req_chan ();
   smpq_rsp_if rsp_chan ();

   sorted_min_priority_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Stimulus and scoreboard storage
   queue_op_type               pending_ops[$];
   queue_result_type           awaited_results[$];
   queue_op_type               on_bus;
   logic [1:0]                 sink_phase;

   // Predictor state: entries kept in ascending key order, head leaves first
   logic [KEY_WIDTH-1:0]       sorted_keys[$];
   logic [HANDLE_WIDTH-1:0]    sorted_handles[$];

   int error_count  = 0;
   int cycle_count  = 0;
   int enq_done     = 0;
   int deq_done     = 0;
   int enq_refused  = 0;
   int deq_refused  = 0;
   int full_reached = 0;

   always #6 clock = ~clock;

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= MAX_PRINTS) begin
         $display("ERROR at %0t ns: %s", $time, msg);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         report_mismatch($sformatf("%s expected 0x%0h got 0x%0h", name, want, got));
      end
   endtask

   task automatic add_op(input logic opcode, input logic [KEY_WIDTH-1:0] key,
                         input logic [HANDLE_WIDTH-1:0] handle, input logic [1:0] phase);
      queue_op_type op;
      op.opcode = opcode;
      op.key    = key;
      op.handle = handle;
      op.phase  = phase;
      pending_ops.push_back(op);
   endtask

   // Apply one operation to the sorted store and return the response it yields
   function automatic queue_result_type apply_queue_op(queue_op_type op);
      queue_result_type r;
      int               pos;
      r = '0;
      if (op.opcode == OP_ENQUEUE) begin
         if (sorted_keys.size() < QUEUE_DEPTH) begin
            // insert ahead of the first entry whose key is not smaller
            pos = 0;
            while (pos < sorted_keys.size() && op.key > sorted_keys[pos]) pos++;
            sorted_keys.insert(pos, op.key);
            sorted_handles.insert(pos, op.handle);
            r.accepted = 1'b1;
            enq_done++;
            if (sorted_keys.size() == QUEUE_DEPTH) full_reached++;
         end else begin
            enq_refused++;
         end
      end else if (sorted_keys.size() > 0) begin
         r.out_key    = sorted_keys.pop_front();
         r.out_handle = sorted_handles.pop_front();
         r.accepted   = 1'b1;
         deq_done++;
      end else begin
         deq_refused++;
      end
      r.count_after = COUNT_WIDTH'(sorted_keys.size());
      r.is_empty    = (sorted_keys.size() == 0);
      r.is_full     = (sorted_keys.size() >= QUEUE_DEPTH);
      return r;
   endfunction

   // Request driver: predict on each transfer, then present the next item or idle
   always @(posedge clock) begin
      int idle_pct;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            awaited_results.push_back(apply_queue_op(on_bus));
         end
         if (!req_chan.valid || req_chan.ready) begin
            idle_pct = 0;
            if (pending_ops.size() > 0) begin
               idle_pct = (pending_ops[0].phase == PH_SRC_IDLE) ? 72 :
                          (pending_ops[0].phase == PH_BOTH)     ? 36 : 0;
            end
            if (pending_ops.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
               on_bus = pending_ops.pop_front();
               req_chan.valid       <= 1'b1;
               req_chan.opcode      <= on_bus.opcode;
               req_chan.item_key    <= on_bus.key;
               req_chan.item_handle <= on_bus.handle;
               sink_phase           <= on_bus.phase;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: compare each transfer with the oldest prediction
   always @(posedge clock) begin
      queue_result_type want;
      int               stall_pct;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (awaited_results.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               want = awaited_results.pop_front();
               check_field("accepted", 32'(want.accepted), 32'(rsp_chan.accepted));
               check_field("out_key", want.out_key, rsp_chan.out_key);
               check_field("out_handle", 32'(want.out_handle), 32'(rsp_chan.out_handle));
               check_field("count_after", 32'(want.count_after),
                           32'(rsp_chan.count_after));
               check_field("is_empty", 32'(want.is_empty), 32'(rsp_chan.is_empty));
               check_field("is_full", 32'(want.is_full), 32'(rsp_chan.is_full));
            end
         end
         stall_pct = (sink_phase == PH_SINK_STALL) ? 72 :
                     (sink_phase == PH_BOTH)       ? 36 : 0;
         rsp_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, awaited_results.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      logic                    opcode;
      logic [KEY_WIDTH-1:0]    key;
      logic [HANDLE_WIDTH-1:0] handle;
      logic [1:0]              phase;
      int                      level;
      int                      overshoot;
      bit                      filling;
      int                      sel;

      clock                = 1'b0;
      reset                = 1'b1;
      sink_phase           = PH_STEADY;
      req_chan.valid       = 1'b0;
      req_chan.opcode      = OP_ENQUEUE;
      req_chan.item_key    = '0;
      req_chan.item_handle = '0;
      rsp_chan.ready       = 1'b0;

      // Directed: dequeue while empty, key extremes, ties at min, mid and max
      add_op(OP_DEQUEUE, 32'h0, 16'h0, PH_STEADY);
      add_op(OP_ENQUEUE, 32'hFFFF_FFFF, 16'hFFFF, PH_STEADY);
      add_op(OP_ENQUEUE, 32'h0, 16'h0000, PH_STEADY);
      add_op(OP_ENQUEUE, 32'd5, 16'h0001, PH_STEADY);
      add_op(OP_ENQUEUE, 32'd5, 16'h0002, PH_STEADY);
      add_op(OP_ENQUEUE, 32'd5, 16'h0003, PH_STEADY);
      add_op(OP_ENQUEUE, 32'hFFFF_FFFF, 16'h1234, PH_STEADY);
      add_op(OP_ENQUEUE, 32'h0, 16'hAAAA, PH_STEADY);
      add_op(OP_ENQUEUE, 32'h8000_0000, 16'h5555, PH_STEADY);
      // drain everything, then one more on the empty queue
      repeat (9) add_op(OP_DEQUEUE, 32'hFFFF_FFFF, 16'hFFFF, PH_STEADY);

      // Random: swing between filling and draining so full and empty both recur
      level     = 0;
      overshoot = 0;
      filling   = 1'b1;
      for (int n = 0; n < RANDOM_OPS; n++) begin
         phase  = 2'((n / PHASE_LEN) % 4);
         opcode = ($urandom_range(0, 99) < (filling ? 85 : 15)) ? OP_ENQUEUE : OP_DEQUEUE;
         sel    = $urandom_range(0, 99);
         if (sel < 25) begin
            key = $urandom_range(0, 15);
         end else if (sel < 35) begin
            key = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
         end else begin
            key = $urandom;
         end
         handle = 16'($urandom_range(0, 65535));
         add_op(opcode, key, handle, phase);
         // track the fill level to know when to turn around
         if (opcode == OP_ENQUEUE) begin
            if (level < QUEUE_DEPTH) level++;
            else overshoot++;
         end else begin
            if (level > 0) level--;
            else overshoot++;
         end
         if (overshoot >= 3) begin
            filling   = !filling;
            overshoot = 0;
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Hold until every item has transferred and every response has come back
      while (pending_ops.size() > 0 || req_chan.valid) @(posedge clock);
      while (awaited_results.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Enqueues done %0d, refused on full %0d; dequeues done %0d, refused on empty %0d",
               enq_done, enq_refused, deq_done, deq_refused);
      $display("Queue filled to capacity %0d times; %0d mismatches", full_reached, error_count);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/smpq_pkg.sv
rtl/core/smpq_channels.sv
rtl/core/smpq_cell.sv
rtl/core/sorted_min_priority_queue.sv
tb/tb_sorted_min_priority_queue.sv
